[src/plr_pkg.sv]
// ----------------------------------------------------------------------------
// plr_pkg: shared types and constants of the pen line rasterizer
// Coordinate widths, command codes, the queue entry layout and the
// pixel helper that the back part uses.
// ----------------------------------------------------------------------------
package plr_pkg;

	// Width of a pen coordinate; coordinates wrap at this width.
	localparam int COORD_BITS = 12;
	// Width of the coordinate fields on the streams.
	localparam int FIELD_BITS = 12;
	// Field width or coordinate width, whichever is larger.
	localparam int WIDE_BITS = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;
	// Major and minor deltas are nonnegative and need one more bit.
	localparam int DELTA_BITS = COORD_BITS + 1;
	// Error accumulator, signed.
	localparam int ERR_BITS = COORD_BITS + 2;
	// Error times a scale of up to four.
	localparam int SCALED_BITS = ERR_BITS + 3;
	// The minor coordinate can run past the line end at a large scale.
	localparam int MINOR_BITS = COORD_BITS + 2;
	localparam int PIX_EXT_BITS = (MINOR_BITS > FIELD_BITS) ? MINOR_BITS : FIELD_BITS;

	// Command queue between front and back.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	// Configuration port.
	localparam int APB_ADDR_BITS = 3;
	localparam logic [APB_ADDR_BITS-1:0] ADDR_ERROR_SCALE = 3'd0;
	localparam logic [2:0] ERROR_SCALE_RESET = 3'd2;

	// Input item kinds.
	typedef enum logic [2:0] {
		KIND_MOVE_ABS = 3'd0,
		KIND_LINE_ABS = 3'd1,
		KIND_MOVE_REL = 3'd2,
		KIND_LINE_REL = 3'd3,
		KIND_STEP     = 3'd4
	} plr_kind_t;

	// Commands that travel through the queue.
	typedef enum logic [1:0] {
		CMD_LINE    = 2'd0,
		CMD_ABANDON = 2'd1,
		CMD_STEP    = 2'd2
	} plr_cmd_t;

	// One queue entry: a command and, for a line, its walk setup.
	typedef struct packed {
		plr_cmd_t                cmd;
		logic                    steep;
		logic                    minor_down;
		logic [COORD_BITS-1:0]   walk_major;
		logic [COORD_BITS-1:0]   walk_minor;
		logic [COORD_BITS-1:0]   end_major;
		logic [DELTA_BITS-1:0]   delta_major;
		logic [DELTA_BITS-1:0]   delta_minor;
	} plr_entry_t;

	// Low field bits of a coordinate, taken after sign extension.
	function automatic logic [FIELD_BITS-1:0] pixel_of(input logic signed [MINOR_BITS-1:0] v);
		logic signed [PIX_EXT_BITS-1:0] e;
		e = PIX_EXT_BITS'(v);
		return e[FIELD_BITS-1:0];
	endfunction

endpackage

[src/plr_front.sv]
// ----------------------------------------------------------------------------
// plr_front: command decode and line setup
// Accepts input beats, keeps the pen position, and turns each known command into
// a queue entry; line commands get their full Bresenham setup here.
// ----------------------------------------------------------------------------
module plr_front
	import plr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            in_kind,
	input  logic [FIELD_BITS-1:0] in_x,
	input  logic [FIELD_BITS-1:0] in_y,
	output logic                  push,
	output plr_entry_t            push_entry,
	input  logic                  fifo_full
);

	logic                  pen_we;
	logic [COORD_BITS-1:0] pen_x_q, pen_y_q;
	logic                  valid_s1;
	plr_cmd_t              cmd_s1, cmd_d;
	logic                  cmd_ok;
	logic [COORD_BITS-1:0] pen_x_s1, pen_y_s1, tgt_x_s1, tgt_y_s1;
	logic [COORD_BITS-1:0] abs_x, abs_y, tgt_x, tgt_y;
	logic signed [WIDE_BITS-1:0] ext_x, ext_y;
	logic                  accept;

	// Offsets and absolute targets, wrapped to the coordinate width.
	assign ext_x = WIDE_BITS'($signed(in_x));
	assign ext_y = WIDE_BITS'($signed(in_y));
	assign abs_x = ext_x[COORD_BITS-1:0];
	assign abs_y = ext_y[COORD_BITS-1:0];

	assign in_ready = !valid_s1 || !fifo_full;
	assign push     = valid_s1 && !fifo_full;
	assign accept   = in_valid && in_ready;

	// Decode the kind into a queue command and the new pen target.
	always_comb begin
		cmd_d  = CMD_STEP;
		cmd_ok = 1'b1;
		pen_we = 1'b0;
		tgt_x  = abs_x;
		tgt_y  = abs_y;
		unique case (in_kind)
			KIND_MOVE_ABS: begin
				cmd_d  = CMD_ABANDON;
				pen_we = 1'b1;
			end
			KIND_LINE_ABS: begin
				cmd_d  = CMD_LINE;
				pen_we = 1'b1;
			end
			KIND_MOVE_REL: begin
				cmd_d  = CMD_ABANDON;
				pen_we = 1'b1;
				tgt_x  = pen_x_q + abs_x;
				tgt_y  = pen_y_q + abs_y;
			end
			KIND_LINE_REL: begin
				cmd_d  = CMD_LINE;
				pen_we = 1'b1;
				tgt_x  = pen_x_q + abs_x;
				tgt_y  = pen_y_q + abs_y;
			end
			KIND_STEP: begin
				cmd_d = CMD_STEP;
			end
			default: begin
				cmd_ok = 1'b0;
			end
		endcase
	end

	// Pen position and stage-one control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q  <= '0;
			pen_y_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept && pen_we) begin
				pen_x_q <= tgt_x;
				pen_y_q <= tgt_y;
			end
			if (accept) begin
				valid_s1 <= cmd_ok;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Stage-one payload: command, old pen and target.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd_d;
			pen_x_s1 <= pen_x_q;
			pen_y_s1 <= pen_y_q;
			tgt_x_s1 <= tgt_x;
			tgt_y_s1 <= tgt_y;
		end
	end

	// Line setup: pick the major axis, order the ends, take the deltas.
	logic signed [COORD_BITS:0] dx, dy, db;
	logic [COORD_BITS:0]        mag_dx, mag_dy;
	logic                       steep;
	logic signed [COORD_BITS-1:0] a0, b0, a1, b1, sa0, sb0, sa1, sb1;
	logic                       swap;

	always_comb begin
		dx     = $signed({tgt_x_s1[COORD_BITS-1], tgt_x_s1})
		         - $signed({pen_x_s1[COORD_BITS-1], pen_x_s1});
		dy     = $signed({tgt_y_s1[COORD_BITS-1], tgt_y_s1})
		         - $signed({pen_y_s1[COORD_BITS-1], pen_y_s1});
		mag_dx = dx[COORD_BITS] ? -dx : dx;
		mag_dy = dy[COORD_BITS] ? -dy : dy;
		steep  = mag_dy > mag_dx;
		if (steep) begin
			a0 = $signed(pen_y_s1);
			b0 = $signed(pen_x_s1);
			a1 = $signed(tgt_y_s1);
			b1 = $signed(tgt_x_s1);
		end else begin
			a0 = $signed(pen_x_s1);
			b0 = $signed(pen_y_s1);
			a1 = $signed(tgt_x_s1);
			b1 = $signed(tgt_y_s1);
		end
		swap = a0 > a1;
		sa0  = swap ? a1 : a0;
		sb0  = swap ? b1 : b0;
		sa1  = swap ? a0 : a1;
		sb1  = swap ? b0 : b1;
		db   = $signed({sb1[COORD_BITS-1], sb1}) - $signed({sb0[COORD_BITS-1], sb0});

		push_entry.cmd         = cmd_s1;
		push_entry.steep       = steep;
		push_entry.minor_down  = !(sb0 < sb1);
		push_entry.walk_major  = sa0;
		push_entry.walk_minor  = sb0;
		push_entry.end_major   = sa1;
		push_entry.delta_major = DELTA_BITS'($signed({sa1[COORD_BITS-1], sa1})
		                         - $signed({sa0[COORD_BITS-1], sa0}));
		push_entry.delta_minor = db[COORD_BITS] ? DELTA_BITS'(-db) : DELTA_BITS'(db);
	end

endmodule

[src/plr_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// plr_cmd_fifo: command queue
// A short first-in first-out queue of decoded commands between the front
// and the back, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module plr_cmd_fifo
	import plr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  plr_entry_t push_entry,
	input  logic       pop,
	output plr_entry_t head,
	output logic       empty,
	output logic       full
);

	plr_entry_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0]  count_q;

	assign empty = count_q == '0;
	assign full  = count_q == FIFO_CNT_BITS'(FIFO_DEPTH);
	assign head  = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("command queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("command queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_BITS'(FIFO_DEPTH))
		else $error("command queue count out of range");
	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("command queue count missed a push");
`endif

endmodule

[src/plr_back.sv]
// ----------------------------------------------------------------------------
// plr_back: Bresenham walk engine
// Takes commands from the queue, keeps the walk state, and puts one pixel
// into the output register for each step tick while a line is active.
// ----------------------------------------------------------------------------
module plr_back
	import plr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [2:0]            error_scale,
	input  plr_entry_t            head,
	input  logic                  empty,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [FIELD_BITS-1:0] out_x,
	output logic [FIELD_BITS-1:0] out_y,
	output logic                  out_last
);

	logic                          line_active_q, steep_q, minor_down_q;
	logic signed [COORD_BITS-1:0]  walk_major_q, end_major_q;
	logic signed [MINOR_BITS-1:0]  walk_minor_q;
	logic [DELTA_BITS-1:0]         delta_major_q, delta_minor_q;
	logic signed [ERR_BITS-1:0]    error_acc_q;
	logic                          out_valid_q, out_last_q;
	logic [FIELD_BITS-1:0]         out_x_q, out_y_q;

	logic                          out_free, produce, load, abandon, last;
	logic signed [ERR_BITS-1:0]    err_sum, err_new;
	logic signed [SCALED_BITS-1:0] err_ext, err_scaled;
	logic                          take_minor;
	logic [FIELD_BITS-1:0]         pix_major, pix_minor;

	assign out_free = !out_valid_q || out_ready;

	// Decide what the head command does this cycle.
	always_comb begin
		pop     = 1'b0;
		produce = 1'b0;
		load    = 1'b0;
		abandon = 1'b0;
		if (!empty) begin
			unique case (head.cmd)
				CMD_LINE: begin
					pop  = 1'b1;
					load = 1'b1;
				end
				CMD_ABANDON: begin
					pop     = 1'b1;
					abandon = 1'b1;
				end
				CMD_STEP: begin
					if (!line_active_q) begin
						pop = 1'b1;
					end else if (out_free) begin
						pop     = 1'b1;
						produce = 1'b1;
					end
				end
				default: begin
					pop = 1'b1;
				end
			endcase
		end
	end

	// One walk step: error update and the scaled compare.
	always_comb begin
		last    = walk_major_q >= end_major_q;
		err_sum = error_acc_q + $signed({1'b0, delta_minor_q});
		err_ext = SCALED_BITS'(err_sum);
		priority if (error_scale <= 3'd1) begin
			err_scaled = err_ext;
		end else if (error_scale == 3'd2) begin
			err_scaled = err_ext <<< 1;
		end else if (error_scale == 3'd3) begin
			err_scaled = err_ext + (err_ext <<< 1);
		end else begin
			err_scaled = err_ext <<< 2;
		end
		take_minor = err_scaled >= $signed(SCALED_BITS'({1'b0, delta_major_q}));
		err_new    = take_minor ? err_sum - $signed({1'b0, delta_major_q}) : err_sum;
		pix_major  = pixel_of(MINOR_BITS'(walk_major_q));
		pix_minor  = pixel_of(walk_minor_q);
	end

	// Walk control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (load) begin
				line_active_q <= 1'b1;
			end else if (abandon || (produce && last)) begin
				line_active_q <= 1'b0;
			end
			if (produce) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk registers and the output register.
	always_ff @(posedge clk) begin
		if (load) begin
			steep_q       <= head.steep;
			minor_down_q  <= head.minor_down;
			walk_major_q  <= $signed(head.walk_major);
			walk_minor_q  <= MINOR_BITS'($signed(head.walk_minor));
			end_major_q   <= $signed(head.end_major);
			delta_major_q <= head.delta_major;
			delta_minor_q <= head.delta_minor;
			error_acc_q   <= '0;
		end else if (produce && !last) begin
			walk_major_q <= walk_major_q + COORD_BITS'(1);
			error_acc_q  <= err_new;
			if (take_minor) begin
				walk_minor_q <= minor_down_q ? walk_minor_q - MINOR_BITS'(1)
				                             : walk_minor_q + MINOR_BITS'(1);
			end
		end
		if (produce) begin
			out_x_q    <= steep_q ? pix_minor : pix_major;
			out_y_q    <= steep_q ? pix_major : pix_minor;
			out_last_q <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_last  = out_last_q;

`ifndef SYNTH
	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(produce && last) |=> !line_active_q)
		else $error("line still active after its last pixel");
	a_line_starts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> line_active_q && error_acc_q == '0)
		else $error("line setup did not start a fresh walk");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		line_active_q |-> walk_major_q <= end_major_q)
		else $error("walk ran past the line end");
	a_pixel_only_active: assert property (@(posedge clk) disable iff (!arst_n)
		produce |-> line_active_q && out_free)
		else $error("pixel issued without an active line or free output");
`endif

endmodule

[src/pen_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// pen_line_rasterizer: pen-plotter line rasterizer
// Keeps a pen position and walks Bresenham lines, one pixel per step tick.
// ----------------------------------------------------------------------------
// The block accepts a new input beat each cycle as long as its four-entry
// command queue has room. A step tick on an active line yields one output
// beat; steps go out at one pixel per cycle while the pixel stream takes
// them, as the walk engine updates its error from its registered walk
// state. A command passes through the decode register and then the queue
// before the walk engine acts on it; each pixel is registered in the walk
// engine's output register and waits there while the pixel stream stalls.
// Move and line commands abandon an unfinished line; step ticks with no
// active line and unused kinds give no output beat. The user must write the
// error scale register through the configuration port only while the block
// is idle; the block itself does not enforce this.
module pen_line_rasterizer
	import plr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// Configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	// Command stream
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [23:0]              s_tdata,   // pos_x [11:0], pos_y [23:12]
	input  logic [2:0]               s_tuser,   // kind [2:0]
	// Pixel stream
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [23:0]              m_tdata,   // pixel_x [11:0], pixel_y [23:12]
	output logic                     m_tlast
);

	logic [2:0]            error_scale_q;
	logic                  push, pop, empty, full;
	plr_entry_t            push_entry, head;
	logic [FIELD_BITS-1:0] pix_x, pix_y;

	// Configuration register.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_scale_q <= ERROR_SCALE_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_ERROR_SCALE) begin
			error_scale_q <= pwdata[2:0];
		end
	end
	assign prdata = (paddr == ADDR_ERROR_SCALE) ? {29'd0, error_scale_q} : 32'd0;

	plr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_kind    (s_tuser),
		.in_x       (s_tdata[11:0]),
		.in_y       (s_tdata[23:12]),
		.push       (push),
		.push_entry (push_entry),
		.fifo_full  (full)
	);

	plr_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	plr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.error_scale (error_scale_q),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_x       (pix_x),
		.out_y       (pix_y),
		.out_last    (m_tlast)
	);

	assign m_tdata = {pix_y, pix_x};

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the pen line rasterizer
// Drives command beats in random bursts, stalls the pixel stream on a
// pattern of its own and compares every pixel beat with a line-walk
// predictor kept in the bench. The error scale is reprogrammed between
// traffic phases through the configuration port and read back.
// ----------------------------------------------------------------------------
module tb_top;
	import plr_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 12;
	localparam int STEP_CAP     = 80;

	// Kinds that the block must ignore.
	localparam logic [2:0] KIND_SPARE_0 = 3'd5;
	localparam logic [2:0] KIND_SPARE_1 = 3'd6;
	localparam logic [2:0] KIND_SPARE_2 = 3'd7;

	localparam logic signed [FIELD_BITS-1:0] FIELD_MIN = 12'sh800;
	localparam logic signed [FIELD_BITS-1:0] FIELD_MAX = 12'sh7FF;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_COIN,
		SINK_SPARSE,
		SINK_STRIDE
	} sink_mode_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] x;
		logic [FIELD_BITS-1:0] y;
		logic                  last;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // pos_x [11:0], pos_y [23:12]
	logic [2:0]  s_tuser = '0;   // kind [2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // pixel_x [11:0], pixel_y [23:12]
	logic        m_tlast;

	pen_line_rasterizer dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted pen, walk state and scale.
	logic signed [COORD_BITS-1:0] pen_x_q = '0;
	logic signed [COORD_BITS-1:0] pen_y_q = '0;
	logic                         line_on = 1'b0;
	logic                         line_steep = 1'b0;
	logic                         line_down = 1'b0;
	logic signed [COORD_BITS-1:0] major_pos = '0;
	logic signed [COORD_BITS-1:0] major_end = '0;
	logic signed [MINOR_BITS-1:0] minor_pos = '0;
	logic signed [DELTA_BITS-1:0] major_span = '0;
	logic signed [DELTA_BITS-1:0] minor_span = '0;
	logic signed [ERR_BITS-1:0]   err_acc = '0;
	logic [2:0]                   scale_reg = ERROR_SCALE_RESET;

	pixel_t pixel_expect[$];
	int     fail_count = 0;
	int     sent_count = 0;
	int     burst_left = 0;
	int     cycle_count = 0;

	function automatic int mag_of(input int v);
		return (v < 0) ? -v : v;
	endfunction

	// Set up a walk from the pen to the target, lower major end first.
	task automatic begin_walk(input logic signed [COORD_BITS-1:0] tx,
			input logic signed [COORD_BITS-1:0] ty);
		int a0, b0, a1, b1, t;
		line_steep = mag_of(int'(ty) - int'(pen_y_q)) > mag_of(int'(tx) - int'(pen_x_q));
		if (line_steep) begin
			a0 = pen_y_q; b0 = pen_x_q; a1 = ty; b1 = tx;
		end else begin
			a0 = pen_x_q; b0 = pen_y_q; a1 = tx; b1 = ty;
		end
		if (a0 > a1) begin
			t = a0; a0 = a1; a1 = t;
			t = b0; b0 = b1; b1 = t;
		end
		major_pos  = a0;
		minor_pos  = b0;
		major_end  = a1;
		major_span = a1 - a0;
		minor_span = mag_of(b1 - b0);
		line_down  = !(b0 < b1);
		err_acc    = '0;
		line_on    = 1'b1;
		pen_x_q    = tx;
		pen_y_q    = ty;
	endtask

	// Apply one accepted command beat and queue the pixel it yields, if any.
	task automatic plot_predict(input logic [2:0] kind, input logic signed [FIELD_BITS-1:0] px,
			input logic signed [FIELD_BITS-1:0] py);
		int     sx, sy, sc, e;
		pixel_t pix;
		case (kind)
			KIND_MOVE_ABS: begin
				line_on = 1'b0;
				pen_x_q = COORD_BITS'(px);
				pen_y_q = COORD_BITS'(py);
			end
			KIND_LINE_ABS: begin
				begin_walk(COORD_BITS'(px), COORD_BITS'(py));
			end
			KIND_MOVE_REL: begin
				line_on = 1'b0;
				pen_x_q = pen_x_q + COORD_BITS'(px);
				pen_y_q = pen_y_q + COORD_BITS'(py);
			end
			KIND_LINE_REL: begin
				begin_walk(pen_x_q + COORD_BITS'(px), pen_y_q + COORD_BITS'(py));
			end
			KIND_STEP: begin
				if (line_on) begin
					sx = line_steep ? int'(minor_pos) : int'(major_pos);
					sy = line_steep ? int'(major_pos) : int'(minor_pos);
					pix.x = FIELD_BITS'(sx);
					pix.y = FIELD_BITS'(sy);
					pix.last = (major_pos >= major_end);
					pixel_expect.push_back(pix);
					if (pix.last) begin
						line_on = 1'b0;
					end else begin
						sc = scale_reg;
						if (sc < 1) sc = 1;
						if (sc > 4) sc = 4;
						major_pos = major_pos + 1;
						e = int'(err_acc) + int'(minor_span);
						if (sc * e >= int'(major_span)) begin
							minor_pos = line_down ? minor_pos - 1 : minor_pos + 1;
							e = e - int'(major_span);
						end
						err_acc = e;
					end
				end
			end
			default: begin
				// Spare kinds leave everything as it is.
			end
		endcase
	endtask

	// Send one command beat, then maybe end the burst with a gap.
	task automatic send_cmd(input logic [2:0] kind, input logic signed [FIELD_BITS-1:0] px,
			input logic signed [FIELD_BITS-1:0] py);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {py, px};
		do @(posedge clk); while (!s_tready);
		plot_predict(kind, px, py);
		sent_count++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(0, 31);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// One configuration transfer: setup cycle, then access until ready.
	task automatic apb_transfer(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_ERROR_SCALE;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write the error scale and read it back.
	task automatic program_scale(input logic [2:0] value);
		logic [31:0] rd;
		apb_transfer(1'b1, 32'(value), rd);
		scale_reg = value;
		apb_transfer(1'b0, '0, rd);
		if (rd !== 32'(scale_reg)) begin
			$error("error_scale: expected %0d, got %0d", scale_reg, rd);
			fail_count++;
		end
	endtask

	// Stop sending and let every pixel and queued command drain out.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pixel_expect.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [FIELD_BITS-1:0] small_offset();
		return FIELD_BITS'($urandom_range(0, 48)) - FIELD_BITS'(24);
	endfunction

	// Random strokes: mostly a line and the steps that walk it, with some
	// early abandons, extra idle steps and raw noise beats mixed in.
	task automatic run_strokes(input int n_items);
		int stop_at, steps, mode;
		stop_at = sent_count + n_items;
		while (sent_count < stop_at) begin
			if ($urandom_range(0, 99) < 15) begin
				send_cmd(3'($urandom_range(0, 7)), FIELD_BITS'($urandom),
					FIELD_BITS'($urandom));
			end else begin
				if ($urandom_range(0, 3) == 0) begin
					if ($urandom_range(0, 1) == 0)
						send_cmd(KIND_MOVE_ABS, FIELD_BITS'($urandom), FIELD_BITS'($urandom));
					else
						send_cmd(KIND_MOVE_REL, small_offset(), small_offset());
				end
				if ($urandom_range(0, 15) == 0)
					send_cmd(KIND_LINE_ABS, FIELD_BITS'($urandom), FIELD_BITS'($urandom));
				else if ($urandom_range(0, 1) == 0)
					send_cmd(KIND_LINE_REL, small_offset(), small_offset());
				else
					send_cmd(KIND_LINE_ABS, FIELD_BITS'(pen_x_q + small_offset()),
						FIELD_BITS'(pen_y_q + small_offset()));
				mode = $urandom_range(0, 9);
				if (mode == 9) begin
					// Walk only part of the line; a later move or line command abandons it.
					repeat ($urandom_range(0, 6))
						send_cmd(KIND_STEP, FIELD_BITS'($urandom), FIELD_BITS'($urandom));
				end else begin
					steps = 0;
					while (line_on && steps < STEP_CAP) begin
						send_cmd(KIND_STEP, FIELD_BITS'($urandom), FIELD_BITS'($urandom));
						steps++;
					end
					if (mode >= 7) begin
						repeat ($urandom_range(1, 3))
							send_cmd(KIND_STEP, FIELD_BITS'($urandom), FIELD_BITS'($urandom));
					end
				end
			end
		end
	endtask

	// Hand-picked beats: field extremes, idle steps, spare kinds mid-line,
	// abandons, a single-pixel line, a flat line and a steep downward one.
	task automatic test_directed();
		logic [31:0] rd;
		apb_transfer(1'b0, '0, rd);
		if (rd !== 32'(ERROR_SCALE_RESET)) begin
			$error("error_scale: expected %0d, got %0d", ERROR_SCALE_RESET, rd);
			fail_count++;
		end
		send_cmd(KIND_STEP, FIELD_MAX, FIELD_MIN);
		send_cmd(KIND_LINE_ABS, 12'sd3, 12'sd1);
		send_cmd(KIND_STEP, '0, '0);
		send_cmd(KIND_SPARE_0, FIELD_MAX, FIELD_MIN);
		repeat (3) send_cmd(KIND_STEP, FIELD_MIN, FIELD_MAX);
		send_cmd(KIND_STEP, '0, '0);
		send_cmd(KIND_MOVE_ABS, FIELD_MIN, FIELD_MAX);
		send_cmd(KIND_LINE_REL, 12'sd2, -12'sd3);
		repeat (2) send_cmd(KIND_STEP, '0, '0);
		send_cmd(KIND_LINE_REL, FIELD_MAX, FIELD_MIN);
		send_cmd(KIND_STEP, '0, '0);
		send_cmd(KIND_MOVE_REL, FIELD_MIN, FIELD_MAX);
		send_cmd(KIND_STEP, '0, '0);
		send_cmd(KIND_LINE_REL, '0, '0);
		send_cmd(KIND_STEP, '0, '0);
		send_cmd(KIND_LINE_REL, 12'sd3, '0);
		repeat (4) send_cmd(KIND_STEP, '0, '0);
		send_cmd(KIND_SPARE_1, FIELD_MIN, FIELD_MAX);
		send_cmd(KIND_SPARE_2, FIELD_MAX, FIELD_MAX);
		wait_drained();
	endtask

	// Every scale code, including the clamped ones, with traffic under each.
	task automatic test_scale_extremes();
		logic [2:0] codes[8] = '{3'd0, 3'd7, 3'd1, 3'd4, 3'd5, 3'd3, 3'd6, 3'd2};
		foreach (codes[i]) begin
			program_scale(codes[i]);
			run_strokes(50);
			wait_drained();
		end
	endtask

	// Long random phases at random scales.
	task automatic test_random_traffic();
		repeat (10) begin
			program_scale(3'($urandom_range(0, 7)));
			run_strokes(70);
			wait_drained();
		end
	endtask

	// Pixel sink: switches between stall patterns at random intervals.
	sink_mode_t sink_mode = SINK_OPEN;
	int         sink_hold = 0;
	always @(posedge clk) begin
		if (sink_hold == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 3));
			sink_hold = $urandom_range(16, 96);
		end else begin
			sink_hold--;
		end
		case (sink_mode)
			SINK_OPEN:   m_tready <= 1'b1;
			SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
			SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
			default:     m_tready <= (cycle_count % 8 == 0);
		endcase
	end

	// Compare each pixel beat with the oldest predicted pixel.
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pixel_expect.size() == 0) begin
				$error("pixel beat with none expected: x %0d y %0d last %0b",
					$signed(m_tdata[11:0]), $signed(m_tdata[23:12]), m_tlast);
				fail_count++;
			end else begin
				want = pixel_expect.pop_front();
				if (m_tdata[11:0] !== want.x) begin
					$error("pixel_x: expected %0d, got %0d", $signed(want.x),
						$signed(m_tdata[11:0]));
					fail_count++;
				end
				if (m_tdata[23:12] !== want.y) begin
					$error("pixel_y: expected %0d, got %0d", $signed(want.y),
						$signed(m_tdata[23:12]));
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last_pixel: expected %0b, got %0b", want.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_scale_extremes();
		test_random_traffic();
		wait_drained();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[pen_line_rasterizer.f]
src/plr_pkg.sv
src/plr_front.sv
src/plr_cmd_fifo.sv
src/plr_back.sv
src/pen_line_rasterizer.sv
verif/tb_top.sv
